### src/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types and constants of the heightmap pair shader pipeline.
// ----------------------------------------------------------------------------
package hps_pkg;

  // field widths
  localparam int HEIGHT_W   = 8;
  localparam int TERRAIN_W  = 4;
  localparam int INDEX_W    = 13;
  localparam int COLOR_W    = 8;
  localparam int LIGHT_AW   = 9;
  localparam int DEPTH_W    = 7;
  localparam int SLICE_AW   = 9;

  // table geometry
  localparam int LIGHT_DEPTH   = 512;
  localparam int SLICE_DEPTH   = 512;
  localparam int TERRAIN_COUNT = 16;

  // shading constants
  localparam logic [HEIGHT_W:0]   LIGHT_BIAS  = 9'd255;
  localparam logic [SLICE_AW:0]   PAL_BIAS    = 10'd256;
  localparam logic [SLICE_AW-1:0] SHADOW_BIAS = 9'd128;

  // item commands
  typedef enum logic [1:0] {
    CMD_SHADE   = 2'd0,
    CMD_LIGHT   = 2'd1,
    CMD_PALETTE = 2'd2
  } cmd_t;

  // per-column shading inputs
  typedef struct packed {
    logic [LIGHT_AW-1:0]  light_idx;
    logic [DEPTH_W-1:0]   depth;
    logic                 shadow;
    logic [TERRAIN_W-1:0] terrain;
  } lane_t;

  // stage one payload
  typedef struct packed {
    logic [1:0]           cmd;
    lane_t                lane_e;
    lane_t                lane_o;
    logic [INDEX_W-1:0]   idx;
    logic [HEIGHT_W-1:0]  wdata;
  } s1_t;

  // stage two payload: stage one plus the light values
  typedef struct packed {
    s1_t                  base;
    logic [COLOR_W-1:0]   light_e;
    logic [COLOR_W-1:0]   light_o;
  } s2_t;

  // status of the palette stage
  typedef struct packed {
    logic valid;
    logic shade;
  } pal_stat_t;

endpackage

### src/hps_front.sv
// ----------------------------------------------------------------------------
// hps_front
// First stage: lane selection, light index, depth term and terrain clamp.
// ----------------------------------------------------------------------------
module hps_front #(
  parameter int TERRAIN_COUNT = hps_pkg::TERRAIN_COUNT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_valid,
  input  logic [1:0]                     in_command,
  input  logic [hps_pkg::HEIGHT_W-1:0]   in_height_left,
  input  logic [hps_pkg::HEIGHT_W-1:0]   in_height_even,
  input  logic [hps_pkg::HEIGHT_W-1:0]   in_height_odd,
  input  logic [hps_pkg::HEIGHT_W-1:0]   in_height_next,
  input  logic [hps_pkg::HEIGHT_W-1:0]   in_height_next2,
  input  logic                           in_pair_double,
  input  logic [hps_pkg::TERRAIN_W-1:0]  in_terrain_even,
  input  logic                           in_shadow_even,
  input  logic [hps_pkg::TERRAIN_W-1:0]  in_terrain_odd,
  input  logic                           in_shadow_odd,
  input  logic [hps_pkg::INDEX_W-1:0]    in_table_index,
  output logic                           s1_valid_r,
  output hps_pkg::s1_t                   s1_r
);

  localparam logic [hps_pkg::TERRAIN_W:0] TC_LIM = (hps_pkg::TERRAIN_W + 1)'(TERRAIN_COUNT);
  localparam logic [hps_pkg::TERRAIN_W-1:0] TC_MAX =
    hps_pkg::TERRAIN_W'(TERRAIN_COUNT - 1);

  hps_pkg::lane_t lane_e_nxt;
  hps_pkg::lane_t lane_o_nxt;
  hps_pkg::s1_t   s1_nxt;
  logic [hps_pkg::HEIGHT_W-1:0]  odd_left;
  logic [hps_pkg::HEIGHT_W-1:0]  odd_right;
  logic [hps_pkg::HEIGHT_W-1:0]  dep_e_full;
  logic [hps_pkg::HEIGHT_W-1:0]  dep_o_full;
  logic [hps_pkg::TERRAIN_W-1:0] ter_e;
  logic [hps_pkg::TERRAIN_W-1:0] ter_o;

  // saturate terrain codes past the table count
  always_comb begin
    ter_e = ({1'b0, in_terrain_even} >= TC_LIM) ? TC_MAX : in_terrain_even;
    ter_o = ({1'b0, in_terrain_odd}  >= TC_LIM) ? TC_MAX : in_terrain_odd;
  end

  // odd column neighbors depend on the double-level flag
  assign odd_left  = in_pair_double ? in_height_odd   : in_height_even;
  assign odd_right = in_pair_double ? in_height_next2 : in_height_next;

  // half depth below the top
  assign dep_e_full = hps_pkg::HEIGHT_W'(hps_pkg::LIGHT_BIAS - {1'b0, in_height_even});
  assign dep_o_full = hps_pkg::HEIGHT_W'(hps_pkg::LIGHT_BIAS - {1'b0, in_height_odd});

  always_comb begin
    lane_o_nxt.light_idx = hps_pkg::LIGHT_AW'(hps_pkg::LIGHT_BIAS - {1'b0, odd_left}
                                              + {1'b0, odd_right});
    lane_o_nxt.depth     = dep_o_full[hps_pkg::HEIGHT_W-1:1];
    lane_o_nxt.shadow    = in_shadow_odd;
    lane_o_nxt.terrain   = ter_o;
    // a double-level pair shades the even pixel as the odd one
    if (in_pair_double) begin
      lane_e_nxt = lane_o_nxt;
    end else begin
      lane_e_nxt.light_idx = hps_pkg::LIGHT_AW'(hps_pkg::LIGHT_BIAS
                                                - {1'b0, in_height_left}
                                                + {1'b0, in_height_odd});
      lane_e_nxt.depth     = dep_e_full[hps_pkg::HEIGHT_W-1:1];
      lane_e_nxt.shadow    = in_shadow_even;
      lane_e_nxt.terrain   = ter_e;
    end
    s1_nxt.cmd    = in_command;
    s1_nxt.lane_e = lane_e_nxt;
    s1_nxt.lane_o = lane_o_nxt;
    s1_nxt.idx    = in_table_index;
    s1_nxt.wdata  = in_height_even;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

### src/hps_light.sv
// ----------------------------------------------------------------------------
// hps_light
// Second stage: slope light table, two reads and one write per cycle.
// ----------------------------------------------------------------------------
module hps_light (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          s1_valid_r,
  input  hps_pkg::s1_t  s1_r,
  output logic          s2_valid_r,
  output hps_pkg::s2_t  s2_r
);

  logic [hps_pkg::COLOR_W-1:0] light_mem [hps_pkg::LIGHT_DEPTH];
  logic                        light_wr;

  // light writes beyond the table are dropped
  assign light_wr = (hps_pkg::cmd_t'(s1_r.cmd) == hps_pkg::CMD_LIGHT) &&
                    (s1_r.idx[hps_pkg::INDEX_W-1:hps_pkg::LIGHT_AW] == '0);

  // table access in item order, rest of the item carried along
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r.base <= s1_r;
      if (s1_valid_r) begin
        if (light_wr) begin
          light_mem[s1_r.idx[hps_pkg::LIGHT_AW-1:0]] <= s1_r.wdata;
        end
        s2_r.light_e <= light_mem[s1_r.lane_e.light_idx];
        s2_r.light_o <= light_mem[s1_r.lane_o.light_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

endmodule

### src/hps_palette.sv
// ----------------------------------------------------------------------------
// hps_palette
// Third and fourth stages: palette offset, palette table and output register.
// ----------------------------------------------------------------------------
module hps_palette #(
  parameter int TERRAIN_COUNT = hps_pkg::TERRAIN_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          s2_valid_r,
  input  hps_pkg::s2_t                  s2_r,
  output hps_pkg::pal_stat_t            s3_stat,
  output logic                          out_valid_r,
  output logic [hps_pkg::COLOR_W-1:0]   color_even_r,
  output logic [hps_pkg::COLOR_W-1:0]   color_odd_r
);

  localparam int PAL_DEPTH = TERRAIN_COUNT * hps_pkg::SLICE_DEPTH;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);
  localparam logic [hps_pkg::INDEX_W:0] PAL_LIM = (hps_pkg::INDEX_W + 1)'(PAL_DEPTH);

  logic [hps_pkg::COLOR_W-1:0] pal_mem [PAL_DEPTH];

  logic [hps_pkg::SLICE_AW-1:0] off_e;
  logic [hps_pkg::SLICE_AW-1:0] off_o;
  logic [PAL_AW-1:0]            addr_e_nxt;
  logic [PAL_AW-1:0]            addr_o_nxt;

  logic                         s3_valid_r;
  logic [1:0]                   s3_cmd_r;
  logic [PAL_AW-1:0]            s3_addr_e_r;
  logic [PAL_AW-1:0]            s3_addr_o_r;
  logic [hps_pkg::INDEX_W-1:0]  s3_idx_r;
  logic [hps_pkg::COLOR_W-1:0]  s3_wdata_r;
  logic                         s3_shade;
  logic                         pal_wr;

  // light minus depth, biased into the slice, halved when shadowed
  function automatic logic [hps_pkg::SLICE_AW-1:0] slice_off(
    input logic [hps_pkg::COLOR_W-1:0] light,
    input logic [hps_pkg::DEPTH_W-1:0] depth,
    input logic                        shadow
  );
    logic [hps_pkg::SLICE_AW:0] sum;
    sum = hps_pkg::PAL_BIAS + {2'b00, light} - {3'b000, depth};
    if (shadow) begin
      return hps_pkg::SLICE_AW'({1'b0, sum[hps_pkg::SLICE_AW-1:1]})
             + hps_pkg::SHADOW_BIAS;
    end
    return sum[hps_pkg::SLICE_AW-1:0];
  endfunction

  assign off_e = slice_off(s2_r.light_e, s2_r.base.lane_e.depth, s2_r.base.lane_e.shadow);
  assign off_o = slice_off(s2_r.light_o, s2_r.base.lane_o.depth, s2_r.base.lane_o.shadow);

  // terrain selects the slice; clamped terrain keeps it inside the table
  assign addr_e_nxt = PAL_AW'({s2_r.base.lane_e.terrain, off_e});
  assign addr_o_nxt = PAL_AW'({s2_r.base.lane_o.terrain, off_o});

  // stage three registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cmd_r    <= s2_r.base.cmd;
      s3_addr_e_r <= addr_e_nxt;
      s3_addr_o_r <= addr_o_nxt;
      s3_idx_r    <= s2_r.base.idx;
      s3_wdata_r  <= s2_r.base.wdata;
    end
  end

  assign s3_shade = hps_pkg::cmd_t'(s3_cmd_r) == hps_pkg::CMD_SHADE;
  assign pal_wr   = (hps_pkg::cmd_t'(s3_cmd_r) == hps_pkg::CMD_PALETTE) &&
                    ({1'b0, s3_idx_r} < PAL_LIM);

  assign s3_stat.valid = s3_valid_r;
  assign s3_stat.shade = s3_shade;

  // palette access in item order, read data is the output register
  always_ff @(posedge clk) begin
    if (adv && s3_valid_r) begin
      if (pal_wr) begin
        pal_mem[PAL_AW'(s3_idx_r)] <= s3_wdata_r;
      end
      if (s3_shade) begin
        color_even_r <= pal_mem[s3_addr_e_r];
        color_odd_r  <= pal_mem[s3_addr_o_r];
      end
    end
  end

  // only shade items produce a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r && s3_shade;
    end
  end

endmodule

### src/heightmap_pair_shader_core.sv
// ----------------------------------------------------------------------------
// heightmap_pair_shader_core
// Shades one column pair of a heightmap row per item; also loads the tables.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one item per cycle, valid/stall handshake. Command
//   shade pair produces one result item; light and palette write commands
//   update the tables and produce none. Write data rides on in_height_even.
//   Result channel out_*: color_even and color_odd of the shaded pair.
//   Pipeline: four register stages (index calc, light table read, palette
//   offset, palette table read), the first loaded at acceptance and the
//   last driving out_valid.
//   Throughput: one item per cycle; the pipeline accepts while a result is
//   waiting, and freezes only when the output register is full and stalled.
//   Stall: out_stall with out_valid high holds every stage and raises
//   in_stall in the same cycle; nothing is dropped or repeated.
//   Reset: synchronous rst_n clears all valid bits. Table contents are not
//   cleared; every entry must be written before a shade item reads it.
//   Tables are read and written at fixed stages, so writes and reads
//   take effect in item order.
// ----------------------------------------------------------------------------
module heightmap_pair_shader_core #(
  parameter int TERRAIN_COUNT = hps_pkg::TERRAIN_COUNT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_command,
  input  logic [hps_pkg::HEIGHT_W-1:0]   in_height_left,
  input  logic [hps_pkg::HEIGHT_W-1:0]   in_height_even,
  input  logic [hps_pkg::HEIGHT_W-1:0]   in_height_odd,
  input  logic [hps_pkg::HEIGHT_W-1:0]   in_height_next,
  input  logic [hps_pkg::HEIGHT_W-1:0]   in_height_next2,
  input  logic                           in_pair_double,
  input  logic [hps_pkg::TERRAIN_W-1:0]  in_terrain_even,
  input  logic                           in_shadow_even,
  input  logic [hps_pkg::TERRAIN_W-1:0]  in_terrain_odd,
  input  logic                           in_shadow_odd,
  input  logic [hps_pkg::INDEX_W-1:0]    in_table_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hps_pkg::COLOR_W-1:0]    out_color_even,
  output logic [hps_pkg::COLOR_W-1:0]    out_color_odd
);

  logic               adv;
  logic               s1_valid_r;
  hps_pkg::s1_t       s1_r;
  logic               s2_valid_r;
  hps_pkg::s2_t       s2_r;
  hps_pkg::pal_stat_t s3_stat;

  // whole pipeline moves unless a finished result is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  hps_front #(
    .TERRAIN_COUNT(TERRAIN_COUNT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (in_valid),
    .in_command      (in_command),
    .in_height_left  (in_height_left),
    .in_height_even  (in_height_even),
    .in_height_odd   (in_height_odd),
    .in_height_next  (in_height_next),
    .in_height_next2 (in_height_next2),
    .in_pair_double  (in_pair_double),
    .in_terrain_even (in_terrain_even),
    .in_shadow_even  (in_shadow_even),
    .in_terrain_odd  (in_terrain_odd),
    .in_shadow_odd   (in_shadow_odd),
    .in_table_index  (in_table_index),
    .s1_valid_r      (s1_valid_r),
    .s1_r            (s1_r)
  );

  hps_light u_light (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .s1_valid_r (s1_valid_r),
    .s1_r       (s1_r),
    .s2_valid_r (s2_valid_r),
    .s2_r       (s2_r)
  );

  hps_palette #(
    .TERRAIN_COUNT(TERRAIN_COUNT)
  ) u_palette (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .s2_valid_r   (s2_valid_r),
    .s2_r         (s2_r),
    .s3_stat      (s3_stat),
    .out_valid_r  (out_valid),
    .color_even_r (out_color_even),
    .color_odd_r  (out_color_odd)
  );

`ifndef SYNTH
  // a held result freezes every stage
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(s1_valid_r) && $stable(s2_valid_r)
                               && $stable(s3_stat.valid))
    else $error("pipeline moved while output stalled");

  // a new result comes only from a shade item in the palette stage
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid) |-> $past(s3_stat.valid && s3_stat.shade))
    else $error("result without a shade item");

  // valid bits move one stage per advance
  a_valid_shift: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(adv) |-> s2_valid_r == $past(s1_valid_r)
                                 && s3_stat.valid == $past(s2_valid_r))
    else $error("valid bit lost or duplicated");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for heightmap_pair_shader_core. Table writes are issued
// ahead of every shade item so that no entry is read before it holds data.
// A local shading model follows each accepted item and queues the colors
// that the result channel must return, in order. Both channels idle and
// stall at random, with bursts of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int GAP_MAX        = 18;
  localparam int STALL_MAX      = 18;
  localparam int ITEM_TARGET    = 1500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int PALETTE_DEPTH  = hps_pkg::TERRAIN_COUNT * hps_pkg::SLICE_DEPTH;
  localparam logic [hps_pkg::TERRAIN_W-1:0] TERRAIN_TOP =
    hps_pkg::TERRAIN_W'(hps_pkg::TERRAIN_COUNT - 1);
  localparam logic [hps_pkg::INDEX_W-1:0] LIGHT_TOP =
    hps_pkg::INDEX_W'(hps_pkg::LIGHT_DEPTH - 1);
  localparam logic [hps_pkg::INDEX_W-1:0] LIGHT_PAST =
    hps_pkg::INDEX_W'(hps_pkg::LIGHT_DEPTH);
  localparam logic [hps_pkg::INDEX_W-1:0] PALETTE_TOP =
    hps_pkg::INDEX_W'(PALETTE_DEPTH - 1);

  typedef struct packed {
    logic [1:0]                    command;
    logic [hps_pkg::HEIGHT_W-1:0]  h_left;
    logic [hps_pkg::HEIGHT_W-1:0]  h_even;
    logic [hps_pkg::HEIGHT_W-1:0]  h_odd;
    logic [hps_pkg::HEIGHT_W-1:0]  h_next;
    logic [hps_pkg::HEIGHT_W-1:0]  h_next2;
    logic                          dbl;
    logic [hps_pkg::TERRAIN_W-1:0] t_even;
    logic                          s_even;
    logic [hps_pkg::TERRAIN_W-1:0] t_odd;
    logic                          s_odd;
    logic [hps_pkg::INDEX_W-1:0]   index;
  } pair_item_t;

  typedef struct packed {
    logic [hps_pkg::COLOR_W-1:0] even;
    logic [hps_pkg::COLOR_W-1:0] odd;
  } color_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [hps_pkg::COLOR_W-1:0] out_color_even;
  logic [hps_pkg::COLOR_W-1:0] out_color_odd;
  pair_item_t drv = '0;

  // pending column pairs and expected colors
  pair_item_t  pair_q[$];
  color_pair_t color_q[$];
  int err_cnt = 0;

  // table contents as seen by the checker, updated at acceptance
  logic [hps_pkg::COLOR_W-1:0] light_mem[hps_pkg::LIGHT_DEPTH];
  logic [hps_pkg::COLOR_W-1:0] palette_mem[PALETTE_DEPTH];

  // table contents as seen by the item generator, and which entries are set
  logic [hps_pkg::COLOR_W-1:0] gen_light[hps_pkg::LIGHT_DEPTH];
  logic [hps_pkg::COLOR_W-1:0] gen_palette[PALETTE_DEPTH];
  bit                          light_set[hps_pkg::LIGHT_DEPTH];
  bit                          palette_set[PALETTE_DEPTH];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  heightmap_pair_shader_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (drv.command),
    .in_height_left (drv.h_left),
    .in_height_even (drv.h_even),
    .in_height_odd  (drv.h_odd),
    .in_height_next (drv.h_next),
    .in_height_next2(drv.h_next2),
    .in_pair_double (drv.dbl),
    .in_terrain_even(drv.t_even),
    .in_shadow_even (drv.s_even),
    .in_terrain_odd (drv.t_odd),
    .in_shadow_odd  (drv.s_odd),
    .in_table_index (drv.index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_color_even (out_color_even),
    .out_color_odd  (out_color_odd)
  );

  // random byte for heights and table data
  function automatic logic [hps_pkg::HEIGHT_W-1:0] rand_byte();
    return hps_pkg::HEIGHT_W'($urandom_range(0, 255));
  endfunction

  // random table address in a range
  function automatic logic [hps_pkg::INDEX_W-1:0] rand_index(int lo, int hi);
    return hps_pkg::INDEX_W'($urandom_range(lo, hi));
  endfunction

  // slope light address from the two neighbor heights, 0..510
  function automatic logic [hps_pkg::LIGHT_AW-1:0] light_addr(
    logic [hps_pkg::HEIGHT_W-1:0] lft,
    logic [hps_pkg::HEIGHT_W-1:0] rgt
  );
    int a;
    a = 255 - int'(lft) + int'(rgt);
    return a[hps_pkg::LIGHT_AW-1:0];
  endfunction

  // palette offset within a terrain slice, always 129..511
  function automatic logic [hps_pkg::SLICE_AW-1:0] slice_offset(
    logic [hps_pkg::COLOR_W-1:0]  lite,
    logic [hps_pkg::HEIGHT_W-1:0] h,
    logic                         shadowed
  );
    int v;
    int off;
    v = int'(lite) - ((255 - int'(h)) >> 1);
    // shadow halves the signed value, rounding down; v + 256 is never negative
    if (shadowed) off = ((v + 256) >> 1) + 128;
    else off = v + 256;
    return off[hps_pkg::SLICE_AW-1:0];
  endfunction

  function automatic logic [hps_pkg::COLOR_W-1:0] column_color(
    logic [hps_pkg::HEIGHT_W-1:0]  lft,
    logic [hps_pkg::HEIGHT_W-1:0]  rgt,
    logic [hps_pkg::HEIGHT_W-1:0]  h,
    logic [hps_pkg::TERRAIN_W-1:0] terrain,
    logic                          shadowed
  );
    logic [hps_pkg::COLOR_W-1:0] lite;
    lite = light_mem[light_addr(lft, rgt)];
    return palette_mem[{terrain, slice_offset(lite, h, shadowed)}];
  endfunction

  // update tables or queue the expected colors of one accepted item
  task automatic apply_pair(pair_item_t it);
    color_pair_t c;
    case (it.command)
      hps_pkg::CMD_LIGHT: begin
        if (it.index < hps_pkg::LIGHT_DEPTH) begin
          light_mem[it.index[hps_pkg::LIGHT_AW-1:0]] = it.h_even;
        end
      end
      hps_pkg::CMD_PALETTE: begin
        if (it.index < PALETTE_DEPTH) palette_mem[it.index] = it.h_even;
      end
      hps_pkg::CMD_SHADE: begin
        if (it.dbl) begin
          // double level: odd column shaded once, even column fields unused
          c.even = column_color(it.h_odd, it.h_next2, it.h_odd, it.t_odd, it.s_odd);
          c.odd  = c.even;
        end else begin
          c.even = column_color(it.h_left, it.h_odd, it.h_even, it.t_even, it.s_even);
          c.odd  = column_color(it.h_even, it.h_next, it.h_odd, it.t_odd, it.s_odd);
        end
        color_q.push_back(c);
      end
      default: ;
    endcase
  endtask

  function automatic pair_item_t random_pair();
    pair_item_t it;
    it.command = hps_pkg::CMD_SHADE;
    it.h_left  = rand_byte();
    it.h_even  = rand_byte();
    it.h_odd   = rand_byte();
    it.h_next  = rand_byte();
    it.h_next2 = rand_byte();
    it.dbl     = 1'($urandom_range(0, 1));
    it.t_even  = hps_pkg::TERRAIN_W'($urandom_range(0, hps_pkg::TERRAIN_COUNT - 1));
    it.s_even  = 1'($urandom_range(0, 1));
    it.t_odd   = hps_pkg::TERRAIN_W'($urandom_range(0, hps_pkg::TERRAIN_COUNT - 1));
    it.s_odd   = 1'($urandom_range(0, 1));
    it.index   = rand_index(0, PALETTE_DEPTH - 1);
    return it;
  endfunction

  task automatic queue_write(logic [1:0] cmd, logic [hps_pkg::INDEX_W-1:0] idx,
                             logic [hps_pkg::COLOR_W-1:0] data);
    pair_item_t it;
    it = random_pair();
    it.command = cmd;
    it.index   = idx;
    it.h_even  = data;
    if (cmd == hps_pkg::CMD_LIGHT && idx < hps_pkg::LIGHT_DEPTH) begin
      gen_light[idx[hps_pkg::LIGHT_AW-1:0]] = data;
      light_set[idx[hps_pkg::LIGHT_AW-1:0]] = 1'b1;
    end
    if (cmd == hps_pkg::CMD_PALETTE && idx < PALETTE_DEPTH) begin
      gen_palette[idx] = data;
      palette_set[idx] = 1'b1;
    end
    pair_q.push_back(it);
  endtask

  // write any entry that this column is about to read and nobody has set yet
  task automatic prime_column(logic [hps_pkg::HEIGHT_W-1:0] lft,
                              logic [hps_pkg::HEIGHT_W-1:0] rgt,
                              logic [hps_pkg::HEIGHT_W-1:0] h,
                              logic [hps_pkg::TERRAIN_W-1:0] terrain,
                              logic shadowed);
    logic [hps_pkg::LIGHT_AW-1:0] li;
    logic [hps_pkg::INDEX_W-1:0]  pa;
    li = light_addr(lft, rgt);
    if (!light_set[li]) queue_write(hps_pkg::CMD_LIGHT, {4'd0, li}, rand_byte());
    pa = {terrain, slice_offset(gen_light[li], h, shadowed)};
    if (!palette_set[pa]) queue_write(hps_pkg::CMD_PALETTE, pa, rand_byte());
  endtask

  task automatic queue_shade(pair_item_t it);
    it.command = hps_pkg::CMD_SHADE;
    if (it.dbl) begin
      prime_column(it.h_odd, it.h_next2, it.h_odd, it.t_odd, it.s_odd);
    end else begin
      prime_column(it.h_left, it.h_odd, it.h_even, it.t_even, it.s_even);
      prime_column(it.h_even, it.h_next, it.h_odd, it.t_odd, it.s_odd);
    end
    pair_q.push_back(it);
  endtask

  // input driver: random gap after each accepted item, bursts now and then
  int  in_gap = 0;
  bit  in_burst = 1'b0;
  always @(posedge clk) begin : drive_proc
    logic nxt_valid;
    if (rst_n) begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        apply_pair(drv);
        if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : int'($urandom_range(0, GAP_MAX));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pair_q.size() > 0) begin
          drv <= pair_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // result monitor: compare each result item, then stall for a random while
  int stall_cnt = 0;
  bit out_burst = 1'b0;
  always @(posedge clk) begin : check_proc
    color_pair_t exp_c;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (color_q.size() == 0) begin
          $error("unexpected result item: color_even %0d color_odd %0d",
                 out_color_even, out_color_odd);
          err_cnt++;
        end else begin
          exp_c = color_q.pop_front();
          if (out_color_even !== exp_c.even) begin
            $error("color_even mismatch: expected %0d, actual %0d",
                   exp_c.even, out_color_even);
            err_cnt++;
          end
          if (out_color_odd !== exp_c.odd) begin
            $error("color_odd mismatch: expected %0d, actual %0d",
                   exp_c.odd, out_color_odd);
            err_cnt++;
          end
        end
        if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
        stall_cnt = out_burst ? 0 : int'($urandom_range(0, STALL_MAX));
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    pair_item_t it;
    int pick;
    int ignored;
    ignored = 0;

    // flat ground, all heights zero, terrain extremes
    it = random_pair();
    {it.h_left, it.h_even, it.h_odd, it.h_next, it.h_next2} = '0;
    it.dbl = 1'b0; it.t_even = '0; it.t_odd = TERRAIN_TOP;
    it.s_even = 1'b0; it.s_odd = 1'b0;
    queue_shade(it);
    // all heights at top, both columns shadowed
    it = random_pair();
    {it.h_left, it.h_even, it.h_odd, it.h_next, it.h_next2} = '1;
    it.dbl = 1'b0; it.t_even = TERRAIN_TOP; it.t_odd = '0;
    it.s_even = 1'b1; it.s_odd = 1'b1;
    queue_shade(it);
    // lowest and highest light addresses on each column
    it = random_pair();
    it.dbl = 1'b0; it.h_left = 8'd255; it.h_odd = 8'd0; it.h_even = 8'd0;
    it.h_next = 8'd255;
    queue_shade(it);
    it = random_pair();
    it.dbl = 1'b0; it.h_left = 8'd0; it.h_odd = 8'd255; it.h_even = 8'd255;
    it.h_next = 8'd0;
    queue_shade(it);
    // darkest light at the deepest point under shadow: negative value halved
    queue_write(hps_pkg::CMD_LIGHT, 13'd255, 8'd0);
    it = random_pair();
    it.dbl = 1'b0; it.h_left = 8'd100; it.h_odd = 8'd100; it.h_even = 8'd0;
    it.s_even = 1'b1;
    queue_shade(it);
    // brightest light at the top, plain and shadowed
    queue_write(hps_pkg::CMD_LIGHT, 13'd255, 8'd255);
    it = random_pair();
    it.dbl = 1'b0; it.h_left = 8'd7; it.h_odd = 8'd7; it.h_even = 8'd255;
    it.s_even = 1'b0;
    queue_shade(it);
    it.s_even = 1'b1;
    queue_shade(it);
    // double-level pairs, even column fields at odd values
    it = random_pair();
    it.dbl = 1'b1; it.s_odd = 1'b1; it.h_even = 8'd255; it.t_even = TERRAIN_TOP;
    it.s_even = 1'b1;
    queue_shade(it);
    it = random_pair();
    it.dbl = 1'b1; it.s_odd = 1'b0; it.h_odd = 8'd0; it.h_next2 = 8'd255;
    it.h_even = 8'd0;
    queue_shade(it);
    // top light entry, then light writes past the table
    queue_write(hps_pkg::CMD_LIGHT, LIGHT_TOP, rand_byte());
    queue_write(hps_pkg::CMD_LIGHT, LIGHT_PAST, rand_byte());
    queue_write(hps_pkg::CMD_LIGHT, PALETTE_TOP, rand_byte());
    // palette corner entries
    queue_write(hps_pkg::CMD_PALETTE, '0, rand_byte());
    queue_write(hps_pkg::CMD_PALETTE, PALETTE_TOP, rand_byte());
    // unused command
    it = random_pair();
    it.command = CMD_UNUSED;
    pair_q.push_back(it);
    // rewrite a light entry right before a shade reads it
    queue_write(hps_pkg::CMD_LIGHT, 13'd255, 8'd128);
    it = random_pair();
    it.dbl = 1'b0; it.h_left = 8'd50; it.h_odd = 8'd50; it.h_even = 8'd128;
    queue_shade(it);

    // random traffic, mostly shade items
    while (pair_q.size() < ITEM_TARGET + ignored) begin
      pick = $urandom_range(0, 99);
      it = random_pair();
      if (pick < 60) begin
        it.dbl = ($urandom_range(0, 3) == 0);
        queue_shade(it);
      end else if (pick < 75) begin
        queue_write(hps_pkg::CMD_LIGHT, rand_index(0, hps_pkg::LIGHT_DEPTH - 1),
                    rand_byte());
      end else if (pick < 88) begin
        queue_write(hps_pkg::CMD_PALETTE, rand_index(0, PALETTE_DEPTH - 1),
                    rand_byte());
      end else if (pick < 93) begin
        queue_write(hps_pkg::CMD_LIGHT,
                    rand_index(hps_pkg::LIGHT_DEPTH, PALETTE_DEPTH - 1),
                    rand_byte());
        ignored++;
      end else begin
        it.command = CMD_UNUSED;
        pair_q.push_back(it);
        ignored++;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // drain: every item sent and every expected result seen
    while (pair_q.size() != 0 || in_valid || color_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
